[hdl/matrix_cell_order_generator_macros.svh]
// Assertion helpers shared by the cell order generator.
`ifndef MATRIX_CELL_ORDER_GENERATOR_MACROS_SVH
`define MATRIX_CELL_ORDER_GENERATOR_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define MCOG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define MCOG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/mcog_pkg.sv]
package mcog_pkg;

    localparam int DEF_SIDE = 16;
    localparam int COORD_W  = 6;
    localparam int CELL_W   = 4;
    localparam int CNT_W    = 8;
    localparam int PAT_W    = 2;
    localparam int UPC_W    = 3;

    localparam logic [PAT_W-1:0] PAT_ROW     = 2'd0;
    localparam logic [PAT_W-1:0] PAT_SPIRAL  = 2'd1;
    localparam logic [PAT_W-1:0] PAT_DIAG    = 2'd2;
    localparam logic [PAT_W-1:0] PAT_DIAMOND = 2'd3;

    // Datapath operation selected by the current control word.
    typedef enum logic [2:0] {
        OP_WAIT,
        OP_START,
        OP_ROW,
        OP_SPIRAL,
        OP_DIAG,
        OP_DMSET,
        OP_DMTEST,
        OP_DMGRP
    } t_op;

    typedef logic [UPC_W-1:0] t_upc;

    // Status from the datapath that the sequencer branches on.
    typedef struct packed {
        logic             in_acc;
        logic             last;
        logic [PAT_W-1:0] pattern;
        logic             in_grid;
        logic             hit;
        logic             rowend;
        logic             grpend;
    } t_flags;

endpackage

[hdl/mcog_seq.sv]
module mcog_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mcog_pkg::t_flags i_flags,
    output mcog_pkg::t_op    o_op
);

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_ACCEPT,
        C_INSIDE,
        C_HIT,
        C_ROWEND,
        C_GRPEND
    } t_cond;

    // First true condition wins; disp replaces t1 by the pattern dispatch.
    typedef struct packed {
        mcog_pkg::t_op  op;
        t_cond          c1;
        logic           disp;
        mcog_pkg::t_upc t1;
        t_cond          c2;
        mcog_pkg::t_upc t2;
        mcog_pkg::t_upc tf;
    } t_ctl;

    localparam mcog_pkg::t_upc A_WAIT   = 3'd0;
    localparam mcog_pkg::t_upc A_START  = 3'd1;
    localparam mcog_pkg::t_upc A_ROW    = 3'd2;
    localparam mcog_pkg::t_upc A_SPIRAL = 3'd3;
    localparam mcog_pkg::t_upc A_DIAG   = 3'd4;
    localparam mcog_pkg::t_upc A_DMSET  = 3'd5;
    localparam mcog_pkg::t_upc A_DMTEST = 3'd6;
    localparam mcog_pkg::t_upc A_DMGRP  = 3'd7;

    function automatic t_ctl ctl_rom(input mcog_pkg::t_upc addr);
        t_ctl w;
        unique case (addr)
            A_WAIT:   w = '{mcog_pkg::OP_WAIT,   C_ACCEPT, 1'b1, A_WAIT,
                            C_NEVER,  A_WAIT,  A_WAIT};
            A_START:  w = '{mcog_pkg::OP_START,  C_ALWAYS, 1'b0, A_WAIT,
                            C_NEVER,  A_WAIT,  A_WAIT};
            A_ROW:    w = '{mcog_pkg::OP_ROW,    C_ALWAYS, 1'b0, A_WAIT,
                            C_NEVER,  A_WAIT,  A_WAIT};
            A_SPIRAL: w = '{mcog_pkg::OP_SPIRAL, C_INSIDE, 1'b0, A_WAIT,
                            C_NEVER,  A_WAIT,  A_SPIRAL};
            A_DIAG:   w = '{mcog_pkg::OP_DIAG,   C_ALWAYS, 1'b0, A_WAIT,
                            C_NEVER,  A_WAIT,  A_WAIT};
            A_DMSET:  w = '{mcog_pkg::OP_DMSET,  C_ALWAYS, 1'b0, A_DMTEST,
                            C_NEVER,  A_WAIT,  A_WAIT};
            A_DMTEST: w = '{mcog_pkg::OP_DMTEST, C_HIT,    1'b0, A_WAIT,
                            C_ROWEND, A_DMGRP, A_DMTEST};
            A_DMGRP:  w = '{mcog_pkg::OP_DMGRP,  C_GRPEND, 1'b0, A_WAIT,
                            C_NEVER,  A_WAIT,  A_DMTEST};
            default:  w = '{mcog_pkg::OP_WAIT,   C_ACCEPT, 1'b1, A_WAIT,
                            C_NEVER,  A_WAIT,  A_WAIT};
        endcase
        return w;
    endfunction

    function automatic logic cond_true(input t_cond c, input mcog_pkg::t_flags f);
        logic t;
        unique case (c)
            C_NEVER:  t = 1'b0;
            C_ALWAYS: t = 1'b1;
            C_ACCEPT: t = f.in_acc;
            C_INSIDE: t = f.in_grid;
            C_HIT:    t = f.hit;
            C_ROWEND: t = f.rowend;
            C_GRPEND: t = f.grpend;
            default:  t = 1'b0;
        endcase
        return t;
    endfunction

    function automatic mcog_pkg::t_upc dispatch(input mcog_pkg::t_flags f);
        mcog_pkg::t_upc a;
        if (f.last) begin
            a = A_START;
        end else begin
            unique case (f.pattern)
                mcog_pkg::PAT_ROW:     a = A_ROW;
                mcog_pkg::PAT_SPIRAL:  a = A_SPIRAL;
                mcog_pkg::PAT_DIAG:    a = A_DIAG;
                mcog_pkg::PAT_DIAMOND: a = A_DMSET;
                default:               a = A_ROW;
            endcase
        end
        return a;
    endfunction

    mcog_pkg::t_upc r_upc;
    mcog_pkg::t_upc n_upc;
    t_ctl           ctl;

    assign ctl  = ctl_rom(r_upc);
    assign o_op = ctl.op;

    always_comb begin
        if (cond_true(ctl.c1, i_flags)) begin
            n_upc = ctl.disp ? dispatch(i_flags) : ctl.t1;
        end else if (cond_true(ctl.c2, i_flags)) begin
            n_upc = ctl.t2;
        end else begin
            n_upc = ctl.tf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= A_WAIT;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

[hdl/mcog_dp.sv]
module mcog_dp #(
    parameter int SIDE = mcog_pkg::DEF_SIDE
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mcog_pkg::t_op                  i_op,
    input  logic                           i_in_acc,
    input  logic                           i_restart,
    input  logic                           i_cfg_acc,
    input  logic [mcog_pkg::PAT_W-1:0]     i_cfg_data,
    input  logic                           i_out_ready,
    output mcog_pkg::t_flags               o_flags,
    output logic                           o_out_valid,
    output logic [mcog_pkg::CELL_W-1:0]    o_row,
    output logic [mcog_pkg::CELL_W-1:0]    o_col,
    output logic [mcog_pkg::CNT_W-1:0]     o_position,
    output logic                           o_last
);

    localparam int RW = $clog2(SIDE);

    typedef logic signed [mcog_pkg::COORD_W-1:0] t_coord;
    typedef logic signed [mcog_pkg::COORD_W:0]   t_wide;
    typedef logic [mcog_pkg::COORD_W-1:0]        t_ucnt;

    localparam t_coord C_SIDE    = t_coord'(SIDE);
    localparam t_coord C_SIDE_M1 = t_coord'(SIDE - 1);
    localparam t_coord C_CENTRE  = t_coord'(SIDE / 2);
    localparam t_coord C_NONE    = t_coord'(-1);
    localparam t_wide  W_SIDE    = t_wide'(SIDE);
    localparam t_wide  W_CENTRE  = t_wide'(SIDE / 2);
    localparam t_ucnt  G_SIDE_M1 = t_ucnt'(SIDE - 1);
    localparam t_ucnt  G_LIMIT   = t_ucnt'(2 * SIDE);
    localparam logic [RW-1:0] S_LAST = RW'(SIDE - 1);
    localparam logic [mcog_pkg::CNT_W-1:0] TOTAL_M1 = mcog_pkg::CNT_W'(SIDE * SIDE - 1);

    function automatic t_coord start_coord(input logic [mcog_pkg::PAT_W-1:0] p);
        return (p == mcog_pkg::PAT_SPIRAL || p == mcog_pkg::PAT_DIAMOND) ? C_CENTRE : '0;
    endfunction

    logic [mcog_pkg::PAT_W-1:0] r_pattern, n_pattern;
    logic [mcog_pkg::CNT_W-1:0] r_count, n_count;
    t_coord                     r_wrow, n_wrow;
    t_coord                     r_wcol, n_wcol;
    t_ucnt                      r_len, n_len;
    t_ucnt                      r_prog, n_prog;
    logic [1:0]                 r_dir, n_dir;
    t_ucnt                      r_group, n_group;
    logic [RW-1:0]              r_scan, n_scan;
    t_coord                     r_bound, n_bound;
    logic                       r_out_valid, n_out_valid;
    logic [mcog_pkg::CELL_W-1:0] r_row, n_row;
    logic [mcog_pkg::CELL_W-1:0] r_col, n_col;
    logic [mcog_pkg::CNT_W-1:0] r_pos, n_pos;
    logic                       r_last, n_last;

    // Effective state of an accepted word, after an optional restart.
    t_coord                     st_cur, st_cfg;
    t_coord                     eff_row, eff_col;
    logic [mcog_pkg::CNT_W-1:0] eff_count;
    logic                       eff_last;

    assign st_cur    = start_coord(r_pattern);
    assign st_cfg    = start_coord(i_cfg_data);
    assign eff_row   = i_restart ? st_cur : r_wrow;
    assign eff_col   = i_restart ? st_cur : r_wcol;
    assign eff_count = i_restart ? '0 : r_count;
    assign eff_last  = (eff_count == TOTAL_M1);

    // Spiral: one step along the current leg.
    t_coord sp_row, sp_col;
    t_ucnt  sp_prog;
    logic   sp_legend, sp_in_grid;

    always_comb begin
        sp_row = r_wrow;
        sp_col = r_wcol;
        case (r_dir)
            2'd0:    sp_col = r_wcol - t_coord'(1);
            2'd1:    sp_row = r_wrow - t_coord'(1);
            2'd2:    sp_col = r_wcol + t_coord'(1);
            default: sp_row = r_wrow + t_coord'(1);
        endcase
    end

    assign sp_prog    = r_prog + t_ucnt'(1);
    assign sp_legend  = (sp_prog >= r_len);
    assign sp_in_grid = (sp_row >= 0) && (sp_row < C_SIDE) && (sp_col >= 0) && (sp_col < C_SIDE);

    // Anti-diagonal: step down-left, or open the next group.
    t_coord dg_row, dg_col;
    logic   dg_wrap;
    t_ucnt  dg_g, dg_grow, dg_gcol;

    assign dg_row  = r_wrow + t_coord'(1);
    assign dg_col  = r_wcol - t_coord'(1);
    assign dg_wrap = (dg_row >= C_SIDE) || (dg_col < 0);
    assign dg_g    = r_group + t_ucnt'(1);
    assign dg_grow = (dg_g > G_SIDE_M1) ? (dg_g - G_SIDE_M1) : '0;
    assign dg_gcol = dg_g - dg_grow;

    // Diamond: test the scan row for a cell of the current distance group.
    t_wide dm_r, dm_d, dm_abs, dm_k, dm_a, dm_b, dm_bound;
    logic  dm_hit_a, dm_hit_b, dm_hit, dm_rowend, dm_grpend;

    assign dm_r      = t_wide'(r_scan);
    assign dm_d      = dm_r - W_CENTRE;
    assign dm_abs    = (dm_d < 0) ? -dm_d : dm_d;
    assign dm_k      = t_wide'(r_group) - dm_abs;
    assign dm_a      = W_CENTRE - dm_k;
    assign dm_b      = W_CENTRE + dm_k;
    assign dm_bound  = t_wide'(r_bound);
    assign dm_hit_a  = (dm_k >= 0) && (dm_a >= 0) && (dm_a > dm_bound);
    assign dm_hit_b  = (dm_k > 0) && (dm_b < W_SIDE) && (dm_b > dm_bound);
    assign dm_hit    = dm_hit_a || dm_hit_b;
    assign dm_rowend = (r_scan == S_LAST);
    assign dm_grpend = (r_group >= G_LIMIT);

    assign o_flags.in_acc  = i_in_acc;
    assign o_flags.last    = eff_last;
    assign o_flags.pattern = r_pattern;
    assign o_flags.in_grid = sp_in_grid;
    assign o_flags.hit     = dm_hit;
    assign o_flags.rowend  = dm_rowend;
    assign o_flags.grpend  = dm_grpend;

    always_comb begin
        n_pattern   = r_pattern;
        n_count     = r_count;
        n_wrow      = r_wrow;
        n_wcol      = r_wcol;
        n_len       = r_len;
        n_prog      = r_prog;
        n_dir       = r_dir;
        n_group     = r_group;
        n_scan      = r_scan;
        n_bound     = r_bound;
        n_out_valid = r_out_valid && !i_out_ready;
        n_row       = r_row;
        n_col       = r_col;
        n_pos       = r_pos;
        n_last      = r_last;

        unique case (i_op)
            mcog_pkg::OP_WAIT: begin
                if (i_cfg_acc) begin
                    n_pattern = i_cfg_data;
                    n_count   = '0;
                    n_len     = t_ucnt'(1);
                    n_prog    = '0;
                    n_dir     = '0;
                    n_group   = '0;
                    n_wrow    = st_cfg;
                    n_wcol    = st_cfg;
                end else if (i_in_acc) begin
                    n_out_valid = 1'b1;
                    n_row       = eff_row[mcog_pkg::CELL_W-1:0];
                    n_col       = eff_col[mcog_pkg::CELL_W-1:0];
                    n_pos       = eff_count;
                    n_last      = eff_last;
                    n_count     = eff_last ? eff_count : eff_count + mcog_pkg::CNT_W'(1);
                    if (i_restart) begin
                        n_len   = t_ucnt'(1);
                        n_prog  = '0;
                        n_dir   = '0;
                        n_group = '0;
                        n_wrow  = st_cur;
                        n_wcol  = st_cur;
                    end
                end
            end
            mcog_pkg::OP_START: begin
                n_count = '0;
                n_len   = t_ucnt'(1);
                n_prog  = '0;
                n_dir   = '0;
                n_group = '0;
                n_wrow  = st_cur;
                n_wcol  = st_cur;
            end
            mcog_pkg::OP_ROW: begin
                if (r_wcol == C_SIDE_M1) begin
                    n_wcol = '0;
                    n_wrow = r_wrow + t_coord'(1);
                end else begin
                    n_wcol = r_wcol + t_coord'(1);
                end
            end
            mcog_pkg::OP_SPIRAL: begin
                n_wrow = sp_row;
                n_wcol = sp_col;
                if (sp_legend) begin
                    n_prog = '0;
                    n_dir  = r_dir + 2'd1;
                    if (r_dir[0]) begin
                        n_len = r_len + t_ucnt'(1);
                    end
                end else begin
                    n_prog = sp_prog;
                end
            end
            mcog_pkg::OP_DIAG: begin
                if (dg_wrap) begin
                    n_group = dg_g;
                    n_wrow  = $signed(dg_grow);
                    n_wcol  = $signed(dg_gcol);
                end else begin
                    n_wrow = dg_row;
                    n_wcol = dg_col;
                end
            end
            mcog_pkg::OP_DMSET: begin
                n_scan  = r_wrow[RW-1:0];
                n_bound = r_wcol;
            end
            mcog_pkg::OP_DMTEST: begin
                if (dm_hit) begin
                    n_wrow = t_coord'(r_scan);
                    n_wcol = dm_hit_a ? dm_a[mcog_pkg::COORD_W-1:0]
                                      : dm_b[mcog_pkg::COORD_W-1:0];
                end else begin
                    n_scan  = r_scan + RW'(1);
                    n_bound = C_NONE;
                end
            end
            mcog_pkg::OP_DMGRP: begin
                if (!dm_grpend) begin
                    n_group = r_group + t_ucnt'(1);
                    n_scan  = '0;
                    n_bound = C_NONE;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern   <= mcog_pkg::PAT_ROW;
            r_count     <= '0;
            r_wrow      <= '0;
            r_wcol      <= '0;
            r_len       <= t_ucnt'(1);
            r_prog      <= '0;
            r_dir       <= '0;
            r_group     <= '0;
            r_scan      <= '0;
            r_bound     <= C_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_pattern   <= n_pattern;
            r_count     <= n_count;
            r_wrow      <= n_wrow;
            r_wcol      <= n_wcol;
            r_len       <= n_len;
            r_prog      <= n_prog;
            r_dir       <= n_dir;
            r_group     <= n_group;
            r_scan      <= n_scan;
            r_bound     <= n_bound;
            r_out_valid <= n_out_valid;
        end
        r_row  <= n_row;
        r_col  <= n_col;
        r_pos  <= n_pos;
        r_last <= n_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_row       = r_row;
    assign o_col       = r_col;
    assign o_position  = r_pos;
    assign o_last      = r_last;

endmodule

[hdl/matrix_cell_order_generator.sv]
// Emits the visiting order of a SIDE x SIDE cell grid, one cell for each input word: row and
// column of the cell, its index in the order, and a flag on the final cell, after which the
// order wraps to the first cell. The pattern word (0 row-major, 1 centre spiral, 2 anti-diagonal,
// 3 diamond by distance from the centre) is written on the config channel while the block is
// idle, and restarts the order; a restart bit on an input word does the same before that word's
// cell is emitted. The emitted cell is registered at acceptance, so the output side may stall
// without holding up the walk; the next input word is taken once the sequencer has prepared the
// following cell. Between items the microcoded sequencer runs an advance routine, one datapath step
// per cycle: the row-major or anti-diagonal step, or the wrap to the first cell; for the spiral,
// steps along the legs until the walker is on the grid, which it stays on up to the final cell,
// so the search for an on-grid position ends on its first step; and for the diamond, a set-up
// step, then a test of one grid row per cycle, with a move to the next distance group after the
// last row of a group.
`include "matrix_cell_order_generator_macros.svh"

module matrix_cell_order_generator #(
    parameter int SIDE = mcog_pkg::DEF_SIDE
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input words
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_restart,
    // result words
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [mcog_pkg::CELL_W-1:0] o_row,
    output logic [mcog_pkg::CELL_W-1:0] o_col,
    output logic [mcog_pkg::CNT_W-1:0]  o_position,
    output logic                        o_last,
    // pattern register write
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [mcog_pkg::PAT_W-1:0]  i_cfg_data
);

    localparam logic [mcog_pkg::CNT_W-1:0] TOTAL_M1 = mcog_pkg::CNT_W'(SIDE * SIDE - 1);

    mcog_pkg::t_op    seq_op;
    mcog_pkg::t_flags dp_flags;
    logic             idle;
    logic             in_acc;
    logic             cfg_acc;

    // The sequencer sits in its wait step between items; only there does it take words.
    assign idle = (seq_op == mcog_pkg::OP_WAIT);

    // Hold input words off while a pattern write is pending, and while the result register
    // is full and not being drained this cycle.
    assign o_cfg_ready = idle;
    assign o_in_ready  = idle && !i_cfg_valid && (!o_out_valid || i_out_ready);

    assign in_acc  = i_in_valid && o_in_ready;
    assign cfg_acc = i_cfg_valid && o_cfg_ready;

    // Control program: step counter, control ROM and branch logic.
    mcog_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (dp_flags),
        .o_op    (seq_op)
    );

    // Walk registers, per-pattern step logic and the result register.
    mcog_dp #(
        .SIDE (SIDE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (seq_op),
        .i_in_acc    (in_acc),
        .i_restart   (i_restart),
        .i_cfg_acc   (cfg_acc),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_flags     (dp_flags),
        .o_out_valid (o_out_valid),
        .o_row       (o_row),
        .o_col       (o_col),
        .o_position  (o_position),
        .o_last      (o_last)
    );

    `MCOG_ASSERT_NOW(a_cfg_excl, cfg_acc, !in_acc, "pattern write and input word taken together")
    `MCOG_ASSERT_NEXT(a_restart_first, in_acc && i_restart, o_out_valid && (o_position == '0), "restart did not emit the first cell")
    `MCOG_ASSERT_NOW(a_cell_in_grid, o_out_valid, (int'(o_row) < SIDE) && (int'(o_col) < SIDE), "emitted cell outside the grid")
    `MCOG_ASSERT_NOW(a_last_index, o_out_valid, o_last == (o_position == TOTAL_M1), "final-cell flag disagrees with index")

endmodule

[bench/cell_order_checker.sv]
module cell_order_checker #(
    parameter int SIDE = mcog_pkg::DEF_SIDE
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic                        i_restart,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [mcog_pkg::CELL_W-1:0] i_row,
    input  logic [mcog_pkg::CELL_W-1:0] i_col,
    input  logic [mcog_pkg::CNT_W-1:0]  i_position,
    input  logic                        i_last,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic [mcog_pkg::PAT_W-1:0]  i_cfg_data,
    output int                          o_fail_count,
    output int                          o_pending
);
    import mcog_pkg::*;

    typedef enum logic [1:0] {HEAD_LEFT, HEAD_UP, HEAD_RIGHT, HEAD_DOWN} heading_t;

    typedef struct packed {
        logic [CELL_W-1:0] row;
        logic [CELL_W-1:0] col;
        logic [CNT_W-1:0]  position;
        logic              last;
    } cell_t;

    localparam int CENTRE     = SIDE / 2;
    localparam int REPORT_MAX = 10;

    logic [PAT_W-1:0] pattern_q = PAT_ROW;
    int               cell_index;
    int               walk_row;
    int               walk_col;
    int               leg_len;
    int               leg_steps;
    int               grp_num;
    heading_t         heading;
    cell_t            cells_due[$];
    int               fails = 0;

    // Return the walk to the first cell of the current pattern.
    function void restart_walk();
        cell_index = 0;
        leg_len    = 1;
        leg_steps  = 0;
        heading    = HEAD_LEFT;
        grp_num    = 0;
        if (pattern_q == PAT_SPIRAL || pattern_q == PAT_DIAMOND) begin
            walk_row = CENTRE;
            walk_col = CENTRE;
        end else begin
            walk_row = 0;
            walk_col = 0;
        end
    endfunction

    // Find the first cell of distance group g at or below row r0, right of c0 on row r0.
    function bit diamond_seek(input int g, input int r0, input int c0);
        int k;
        int bound;
        int lo;
        int hi;
        for (int r = r0; r < SIDE; r++) begin
            k     = g - ((r > CENTRE) ? r - CENTRE : CENTRE - r);
            bound = (r == r0) ? c0 : -1;
            lo    = CENTRE - k;
            hi    = CENTRE + k;
            if (k >= 0 && lo >= 0 && lo > bound) begin
                walk_row = r;
                walk_col = lo;
                return 1'b1;
            end
            if (k > 0 && hi < SIDE && hi > bound) begin
                walk_row = r;
                walk_col = hi;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Emit the current cell and advance the walk to the next one.
    function cell_t emit_cell(input logic restart_bit);
        cell_t c;
        bit    found;
        if (restart_bit)
            restart_walk();
        c.row      = walk_row[CELL_W-1:0];
        c.col      = walk_col[CELL_W-1:0];
        c.position = cell_index[CNT_W-1:0];
        c.last     = (cell_index >= SIDE * SIDE - 1);
        if (c.last) begin
            restart_walk();
        end else begin
            case (pattern_q)
                PAT_ROW: begin
                    walk_col++;
                    if (walk_col >= SIDE) begin
                        walk_col = 0;
                        walk_row++;
                    end
                end
                PAT_SPIRAL: begin
                    for (int guard = 0; guard < 8 * SIDE * SIDE; guard++) begin
                        case (heading)
                            HEAD_LEFT:  walk_col--;
                            HEAD_UP:    walk_row--;
                            HEAD_RIGHT: walk_col++;
                            default:    walk_row++;
                        endcase
                        leg_steps++;
                        if (leg_steps >= leg_len) begin
                            leg_steps = 0;
                            if (heading == HEAD_UP || heading == HEAD_DOWN)
                                leg_len++;
                            heading = heading.next();
                        end
                        if (walk_row >= 0 && walk_row < SIDE && walk_col >= 0 && walk_col < SIDE)
                            break;
                    end
                end
                PAT_DIAG: begin
                    walk_row++;
                    walk_col--;
                    if (walk_row >= SIDE || walk_col < 0) begin
                        grp_num++;
                        walk_row = (grp_num > SIDE - 1) ? grp_num - (SIDE - 1) : 0;
                        walk_col = grp_num - walk_row;
                    end
                end
                default: begin
                    found = diamond_seek(grp_num, walk_row, walk_col);
                    while (!found && grp_num < 2 * SIDE) begin
                        grp_num++;
                        found = diamond_seek(grp_num, 0, -1);
                    end
                end
            endcase
            cell_index++;
        end
        return c;
    endfunction

    always @(posedge i_clk) begin : watch
        cell_t want;
        if (!i_rst_n) begin
            pattern_q = PAT_ROW;
            restart_walk();
            cells_due.delete();
        end else begin
            // compare before queuing, so a same-cycle pass-through shows up as a failure
            if (i_out_valid && i_out_ready) begin
                if (cells_due.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_MAX)
                        $display("%0t: unexpected word row %0d col %0d position %0d last %0d",
                                 $time, i_row, i_col, i_position, i_last);
                end else begin
                    want = cells_due.pop_front();
                    if (want.row !== i_row || want.col !== i_col ||
                        want.position !== i_position || want.last !== i_last) begin
                        fails++;
                        if (fails <= REPORT_MAX)
                            $display("%0t: expected row %0d col %0d position %0d last %0d, %s %0d %0d %0d %0d",
                                     $time, want.row, want.col, want.position, want.last,
                                     "got", i_row, i_col, i_position, i_last);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                pattern_q = i_cfg_data;
                restart_walk();
            end
            if (i_in_valid && i_in_ready)
                cells_due.push_back(emit_cell(i_restart));
        end
        o_fail_count <= fails;
        o_pending    <= cells_due.size();
    end

endmodule

[bench/tb_top.sv]
module tb_top;
    import mcog_pkg::*;

    localparam int SIDE         = DEF_SIDE;
    // a diamond group change is the slowest advance
    localparam int DRAIN_CYCLES = 4 * SIDE + 16;
    localparam int STALL_LIMIT  = 100 * SIDE;
    localparam int IDLE_PCT     = 22;
    localparam int RANDOM_WORDS = 830;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    logic              restart   = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [CELL_W-1:0] row;
    logic [CELL_W-1:0] col;
    logic [CNT_W-1:0]  position;
    logic              last_cell;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [PAT_W-1:0]  cfg_data  = PAT_ROW;

    logic [PAT_W-1:0] pat_list[3] = '{PAT_SPIRAL, PAT_DIAMOND, PAT_DIAG};

    int fail_count;
    int pending;
    // set to drop all idling on both sides for a whole phase
    bit calm = 1'b0;

    matrix_cell_order_generator #(
        .SIDE(SIDE)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_restart   (restart),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_row       (row),
        .o_col       (col),
        .o_position  (position),
        .o_last      (last_cell),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    cell_order_checker #(
        .SIDE(SIDE)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_restart    (restart),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_row        (row),
        .i_col        (col),
        .i_position   (position),
        .i_last       (last_cell),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Stall the result side at random, except during a calm phase.
    always @(negedge clk) begin
        out_ready = calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // Count cycles with no handshake on any channel; end the run if the block hangs.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Offer one input word and hold it until accepted. Entered and left on a falling edge;
    // valid is left high so a back-to-back word does not toggle it within one step.
    task automatic send_word(input logic restart_bit);
        if (!calm) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                in_valid = 1'b0;
                restart  = 1'($urandom_range(1));
                @(negedge clk);
            end
        end
        in_valid = 1'b1;
        restart  = restart_bit;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // Write the pattern register once every expected word has drained.
    task automatic write_pattern(input logic [PAT_W-1:0] pat);
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = pat;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        cfg_data  = PAT_W'($urandom_range(3));
    endtask

    // Run one phase: a pattern, then a count of words with restart at the given odds.
    task automatic run_phase(input logic [PAT_W-1:0] pat, input int words, input int restart_pct);
        write_pattern(pat);
        for (int n = 0; n < words; n++)
            send_word($urandom_range(99) < restart_pct);
    endtask

    initial begin : stimulus
        int sent;
        int words;
        logic [PAT_W-1:0] pat;

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // out of reset with restart low: first cell of row-major, then restart mid-walk
        send_word(1'b0);
        send_word(1'b0);
        send_word(1'b0);
        send_word(1'b1);
        send_word(1'b0);

        write_pattern(PAT_SPIRAL);
        repeat (4) send_word(1'b0);
        send_word(1'b1);
        send_word(1'b0);

        write_pattern(PAT_DIAG);
        repeat (3) send_word(1'b0);
        send_word(1'b1);

        write_pattern(PAT_DIAMOND);
        repeat (4) send_word(1'b0);
        // rewrite the same pattern mid-walk: must restart the walk
        write_pattern(PAT_DIAMOND);
        repeat (2) send_word(1'b0);

        write_pattern(PAT_ROW);
        send_word(1'b0);

        // Full walks with wrap for the spiral, diamond and anti-diagonal patterns; the diamond walk runs calm.
        sent = 0;
        foreach (pat_list[i]) begin
            words = SIDE * SIDE + 2 + $urandom_range(20);
            calm  = (pat_list[i] == PAT_DIAMOND);
            write_pattern(pat_list[i]);
            send_word(1'($urandom_range(1)));
            for (int n = 1; n < words; n++)
                send_word(1'b0);
            sent += words;
        end
        calm = 1'b0;

        // Short phases on random patterns with frequent restarts.
        while (sent < RANDOM_WORDS) begin
            pat   = PAT_W'($urandom_range(3));
            words = $urandom_range(5, 40);
            run_phase(pat, words, 10);
            sent += words;
        end

        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
